// ----- hdl/hsv_range_blob_bounding_box_defines.svh -----
// Assertion macros used by the checker file.
`ifndef HSV_RANGE_BLOB_BOUNDING_BOX_DEFINES_SVH
`define HSV_RANGE_BLOB_BOUNDING_BOX_DEFINES_SVH

// Holds in the same cycle as the condition.
`define HSVBB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsvbb same-cycle check failed");

// Holds in the cycle after the condition.
`define HSVBB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsvbb next-cycle check failed");

`endif

// ----- hdl/hsvbb_pkg.sv -----
`default_nettype none
package hsvbb_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int COORD_W    = 11;
  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 3;

  localparam int COL_CAP_INT = (MAX_WIDTH - 1 > 2047) ? 2047 : MAX_WIDTH - 1;
  localparam int ROW_CAP_INT = (MAX_HEIGHT - 1 > 2047) ? 2047 : MAX_HEIGHT - 1;
  localparam logic [COORD_W-1:0] COL_CAP = COORD_W'(COL_CAP_INT);
  localparam logic [COORD_W-1:0] ROW_CAP = COORD_W'(ROW_CAP_INT);

  localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_HIGH = 3'd5;

  localparam logic [CHAN_W-1:0] HUE_LOW_RESET  = 8'd8;
  localparam logic [CHAN_W-1:0] SAT_LOW_RESET  = 8'd132;
  localparam logic [CHAN_W-1:0] VAL_LOW_RESET  = 8'd161;
  localparam logic [CHAN_W-1:0] HUE_HIGH_RESET = 8'd30;
  localparam logic [CHAN_W-1:0] SAT_HIGH_RESET = 8'd255;
  localparam logic [CHAN_W-1:0] VAL_HIGH_RESET = 8'd255;

  typedef struct packed {
    logic [CHAN_W-1:0] hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
    logic              line_last;
    logic              frame_last;
  } pixel_t;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] box_left;
    logic [COORD_W-1:0] box_top;
    logic [COORD_W-1:0] box_right;
    logic [COORD_W-1:0] box_bottom;
  } box_t;

endpackage
`default_nettype wire

// ----- hdl/hsv_range_blob_bounding_box.sv -----
// Finds the bounding box of all pixels in a frame whose hue, saturation and
// brightness lie inside six programmable inclusive bounds, and sends one box
// beat after each pixel beat that carries frame_last. The block takes one
// pixel beat per clock; a frame's last pixel beat goes through input register
// s1 into the box output register. Pixel input stalls only when a box beat is
// still waiting at the output and the next frame's last pixel must load the
// output register. Coordinates saturate at min(2047, frame size limit - 1).
`default_nettype none
module hsv_range_blob_bounding_box
  import hsvbb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pixel_valid,
  output logic                      pixel_stall,
  input  wire pixel_t               pixel,
  output logic                      box_valid,
  input  wire logic                 box_stall,
  output box_t                      box,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CHAN_W-1:0]    cfg_data
);

  logic [CHAN_W-1:0] hue_low, sat_low, val_low, hue_high, sat_high, val_high;

  pixel_t s1;
  logic   s1_valid;
  logic   s1_hold;
  logic   s1_fire;
  logic   match;

  logic [COORD_W-1:0] column_count, row_count;
  logic [COORD_W-1:0] least_column, least_row, greatest_column, greatest_row;
  logic               any_match;

  logic [COORD_W-1:0] least_column_next, least_row_next;
  logic [COORD_W-1:0] greatest_column_next, greatest_row_next;
  logic               any_match_next;
  box_t               box_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_low  <= HUE_LOW_RESET;
      sat_low  <= SAT_LOW_RESET;
      val_low  <= VAL_LOW_RESET;
      hue_high <= HUE_HIGH_RESET;
      sat_high <= SAT_HIGH_RESET;
      val_high <= VAL_HIGH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HUE_LOW:  hue_low  <= cfg_data;
        REG_SAT_LOW:  sat_low  <= cfg_data;
        REG_VAL_LOW:  val_low  <= cfg_data;
        REG_HUE_HIGH: hue_high <= cfg_data;
        REG_SAT_HIGH: sat_high <= cfg_data;
        REG_VAL_HIGH: val_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // A pixel ending a frame waits in the input register while the previous box
  // is still held at the output.
  assign s1_hold     = s1.frame_last && box_valid && box_stall;
  assign pixel_stall = s1_valid && s1_hold;
  assign s1_fire     = s1_valid && !s1_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!pixel_stall) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!pixel_stall && pixel_valid) begin
      s1 <= pixel;
    end
  end

  always_comb begin
    match = (s1.hue >= hue_low) && (s1.hue <= hue_high) &&
            (s1.saturation >= sat_low) && (s1.saturation <= sat_high) &&
            (s1.brightness >= val_low) && (s1.brightness <= val_high);

    least_column_next    = least_column;
    least_row_next       = least_row;
    greatest_column_next = greatest_column;
    greatest_row_next    = greatest_row;
    any_match_next       = any_match || match;
    if (match) begin
      if (column_count < least_column) least_column_next = column_count;
      if (row_count < least_row) least_row_next = row_count;
      if (column_count > greatest_column) greatest_column_next = column_count;
      if (row_count > greatest_row) greatest_row_next = row_count;
    end

    box_next.found      = any_match_next;
    box_next.box_left   = any_match_next ? least_column_next : '0;
    box_next.box_top    = any_match_next ? least_row_next : '0;
    box_next.box_right  = any_match_next ? greatest_column_next : '0;
    box_next.box_bottom = any_match_next ? greatest_row_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_fire && s1.frame_last)) begin
      column_count    <= '0;
      row_count       <= '0;
      least_column    <= '1;
      least_row       <= '1;
      greatest_column <= '0;
      greatest_row    <= '0;
      any_match       <= 1'b0;
    end else if (s1_fire) begin
      least_column    <= least_column_next;
      least_row       <= least_row_next;
      greatest_column <= greatest_column_next;
      greatest_row    <= greatest_row_next;
      any_match       <= any_match_next;
      if (s1.line_last) begin
        column_count <= '0;
        if (row_count < ROW_CAP) row_count <= row_count + 1'b1;
      end else if (column_count < COL_CAP) begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (s1_fire && s1.frame_last) begin
      box_valid <= 1'b1;
    end else if (!box_stall) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1.frame_last) begin
      box <= box_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/hsvbb_checker.sv -----
`default_nettype none
`include "hsv_range_blob_bounding_box_defines.svh"
module hsvbb_checker
  import hsvbb_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   pixel_valid,
  input wire logic   pixel_stall,
  input wire pixel_t pixel,
  input wire logic   box_valid,
  input wire logic   box_stall,
  input wire box_t   box
);

  `HSVBB_ASSERT_NEXT(a_box_held, clk, rst, box_valid && box_stall, box_valid && $stable(box))
  `HSVBB_ASSERT_SAME(a_empty_box_zero, clk, rst, box_valid && !box.found, (box.box_left == '0) && (box.box_top == '0) && (box.box_right == '0) && (box.box_bottom == '0))
  `HSVBB_ASSERT_SAME(a_box_ordered, clk, rst, box_valid && box.found, (box.box_left <= box.box_right) && (box.box_top <= box.box_bottom))
  `HSVBB_ASSERT_SAME(a_box_follows_frame, clk, rst, $rose(box_valid), $past(pixel_valid && !pixel_stall && pixel.frame_last, 2))
  `HSVBB_ASSERT_SAME(a_stall_only_on_full_output, clk, rst, pixel_stall, box_valid && box_stall)

endmodule

bind hsv_range_blob_bounding_box hsvbb_checker u_hsvbb_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel_valid),
  .pixel_stall (pixel_stall),
  .pixel       (pixel),
  .box_valid   (box_valid),
  .box_stall   (box_stall),
  .box         (box)
);
`default_nettype wire
